>>> hw/rtl/msbuf_pkg.sv
// msbuf_pkg: shared types and codes for the multimode sample buffer.
// Holds the item structs, action and mode codes, and register addresses.
// No dependencies.
package msbuf_pkg;

  localparam int CNT_W    = 11;
  localparam int SAMPLE_W = 64;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  // item actions
  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_READ   = 3'd1;
  localparam logic [2:0] ACT_WRITE  = 3'd2;
  localparam logic [2:0] ACT_SETPOS = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // buffer modes
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_RING   = 2'd1;
  localparam logic [1:0] MODE_FIFO   = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_COUNT_ADDR = 3'd0;
  localparam logic [PADDR_W-1:0] REG_MODE_ADDR  = 3'd4;

  typedef struct packed {
    logic [2:0]          action;
    logic [CNT_W-1:0]    entry_index;
    logic [SAMPLE_W-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] read_value;
    logic                status;
    logic [CNT_W-1:0]    write_pos;
    logic                full_res;
  } out_item_t;

endpackage

>>> hw/rtl/multimode_sample_buffer_top.sv
// Results pass from the s1 stage registers into a three-entry output queue that drives out_item.
// One item per cycle while in_stall is low. Sample store: one DEPTH x 65 synchronous RAM (valid bit + sample).
// Reset: control cleared, then a sweep zeroes all valid bits; no items meanwhile.
// A clear item starts the same sweep. A write of element_count with a nonzero effective
// count starts a head reduction (11-step remainder unit) before the next item is taken.
// Depends on msbuf_pkg.
module multimode_sample_buffer_top #(
  parameter int DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  msbuf_pkg::in_item_t             in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output msbuf_pkg::out_item_t            out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [msbuf_pkg::PADDR_W-1:0]   paddr,
  input  logic [msbuf_pkg::PDATA_W-1:0]   pwdata,
  output logic [msbuf_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);
  import msbuf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] CNT_RESET_EFF =
    (32'(COUNT_RESET) > DEPTH) ? CNT_W'(DEPTH) : COUNT_RESET;

  typedef enum logic [1:0] {S_SWEEP, S_IDLE, S_NORM} state_t;

  state_t            state;
  logic [AW-1:0]     sweep_addr;
  logic [3:0]        norm_bit;
  logic [CNT_W-1:0]  norm_rem;
  logic              norm_pend;

  logic [CNT_W-1:0]  element_count;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        buffer_mode;
  logic [CNT_W-1:0]  wp, fill, head;

  logic              s1_valid, s1_status, s1_full, s1_rd_ok;
  logic [CNT_W-1:0]  s1_wp;

  logic [SAMPLE_W:0] mem [DEPTH];
  logic [SAMPLE_W:0] ram_q;

  out_item_t         q_mem [3];
  logic [1:0]        q_wr, q_rd, q_cnt;

  // ---------------- configuration port ----------------
  logic                 cfg_we;
  logic [CNT_W-1:0]     cfg_cnt_raw, cfg_cnt_eff;

  assign pready      = 1'b1;
  assign cfg_we      = psel && penable && pwrite;
  assign cfg_cnt_raw = pwdata[CNT_W-1:0];
  assign cfg_cnt_eff = (32'(cfg_cnt_raw) > DEPTH) ? CNT_W'(DEPTH) : cfg_cnt_raw;

  always_comb begin
    case (paddr)
      REG_COUNT_ADDR: prdata = PDATA_W'(element_count);
      REG_MODE_ADDR:  prdata = PDATA_W'(buffer_mode);
      default:        prdata = '0;
    endcase
  end

  // ---------------- item execution ----------------
  logic              accept, push, pop;
  logic [CNT_W:0]    cnt_x, fsum, fsub, slot_inc, head_inc, norm_t, norm_s;
  logic [CNT_W-1:0]  phys, slot, fill_inc, norm_r;
  logic [CNT_W-1:0]  wp_next, fill_next, head_next;
  logic              status_next, rd_ok_next, clear_hit;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [SAMPLE_W:0] mem_wdata;

  assign in_stall  = (state != S_IDLE) || norm_pend || ((3'(q_cnt) + 3'(s1_valid)) > 3'd2);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (q_cnt != 2'd0);
  assign out_item  = q_mem[q_rd];
  assign pop       = out_valid && !out_stall;
  assign push      = s1_valid;

  assign cnt_x    = {1'b0, cnt};
  assign fsum     = {1'b0, head} + {1'b0, in_item.entry_index};
  assign fsub     = fsum - cnt_x;
  assign slot     = (wp < cnt) ? wp : '0;
  assign slot_inc = {1'b0, slot} + (CNT_W+1)'(1);
  assign head_inc = {1'b0, head} + (CNT_W+1)'(1);
  assign fill_inc = (fill < cnt) ? fill + CNT_W'(1) : fill;

  // one restoring remainder step: head mod count
  assign norm_t = {norm_rem, head[norm_bit]};
  assign norm_s = norm_t - cnt_x;
  assign norm_r = (norm_t >= cnt_x) ? norm_s[CNT_W-1:0] : norm_t[CNT_W-1:0];

  always_comb begin
    if (buffer_mode == MODE_FIFO) begin
      phys = (fsum >= cnt_x) ? fsub[CNT_W-1:0] : fsum[CNT_W-1:0];
    end else begin
      phys = in_item.entry_index;
    end
  end

  always_comb begin
    wp_next     = wp;
    fill_next   = fill;
    head_next   = head;
    status_next = STATUS_OK;
    rd_ok_next  = 1'b0;
    clear_hit   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = sweep_addr;
    mem_wdata   = {1'b1, in_item.sample_in};
    if (state == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
    end else if (accept) begin
      case (in_item.action)
        ACT_APPEND: begin
          if (cnt == '0) begin
            status_next = STATUS_RANGE;
          end else begin
            case (buffer_mode)
              MODE_LINEAR: begin
                if (wp < cnt) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(wp);
                  wp_next   = wp + CNT_W'(1);
                  fill_next = fill_inc;
                end
              end
              MODE_RING: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(slot);
                wp_next   = (slot_inc >= cnt_x) ? '0 : slot_inc[CNT_W-1:0];
                fill_next = fill_inc;
              end
              MODE_FIFO: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(head);
                head_next = (head_inc >= cnt_x) ? '0 : head_inc[CNT_W-1:0];
                fill_next = fill_inc;
              end
              default: begin
              end
            endcase
          end
        end
        ACT_READ: begin
          if (in_item.entry_index >= cnt) begin
            status_next = STATUS_RANGE;
          end else begin
            mem_re     = 1'b1;
            rd_ok_next = 1'b1;
          end
        end
        ACT_WRITE: begin
          if (in_item.entry_index >= cnt) begin
            status_next = STATUS_RANGE;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(phys);
          end
        end
        ACT_SETPOS: begin
          if (in_item.entry_index > cnt) begin
            status_next = STATUS_RANGE;
          end else begin
            wp_next = in_item.entry_index;
          end
        end
        ACT_CLEAR: begin
          wp_next   = '0;
          fill_next = '0;
          head_next = '0;
          clear_hit = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- sample store ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      ram_q <= mem[AW'(phys)];
    end
  end

  // ---------------- output queue payload ----------------
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr].read_value <= (s1_rd_ok && ram_q[SAMPLE_W]) ? ram_q[SAMPLE_W-1:0] : '0;
      q_mem[q_wr].status     <= s1_status;
      q_mem[q_wr].write_pos  <= s1_wp;
      q_mem[q_wr].full_res   <= s1_full;
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      sweep_addr    <= '0;
      norm_bit      <= '0;
      norm_rem      <= '0;
      norm_pend     <= 1'b0;
      element_count <= COUNT_RESET;
      cnt           <= CNT_RESET_EFF;
      buffer_mode   <= MODE_LINEAR;
      wp            <= '0;
      fill          <= '0;
      head          <= '0;
      s1_valid      <= 1'b0;
      s1_status     <= STATUS_OK;
      s1_wp         <= '0;
      s1_full       <= 1'b0;
      s1_rd_ok      <= 1'b0;
      q_wr          <= '0;
      q_rd          <= '0;
      q_cnt         <= '0;
    end else begin
      case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (norm_pend) begin
            norm_pend <= 1'b0;
            // zero count leaves the head as is
            if (cnt != '0) begin
              state    <= S_NORM;
              norm_bit <= 4'(CNT_W - 1);
              norm_rem <= '0;
            end
          end else if (clear_hit) begin
            state      <= S_SWEEP;
            sweep_addr <= '0;
          end
        end
        S_NORM: begin
          norm_rem <= norm_r;
          if (norm_bit == '0) begin
            state <= S_IDLE;
          end else begin
            norm_bit <= norm_bit - 4'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (state == S_NORM && norm_bit == '0) begin
        head <= norm_r;
      end else begin
        head <= head_next;
      end
      wp   <= wp_next;
      fill <= fill_next;

      s1_valid <= accept;
      if (accept) begin
        s1_status <= status_next;
        s1_wp     <= wp_next;
        s1_full   <= (fill_next >= cnt);
        s1_rd_ok  <= rd_ok_next;
      end

      if (push) begin
        q_wr <= (q_wr == 2'd2) ? 2'd0 : q_wr + 2'd1;
      end
      if (pop) begin
        q_rd <= (q_rd == 2'd2) ? 2'd0 : q_rd + 2'd1;
      end
      q_cnt <= q_cnt + 2'(push) - 2'(pop);

      if (cfg_we && paddr == REG_COUNT_ADDR) begin
        element_count <= cfg_cnt_raw;
        cnt           <= cfg_cnt_eff;
        norm_pend     <= 1'b1;
      end
      if (cfg_we && paddr == REG_MODE_ADDR) begin
        buffer_mode <= pwdata[1:0];
      end
    end
  end

endmodule

>>> bench/multimode_sample_buffer_top_tb.sv
// Self-checking bench for multimode_sample_buffer_top: directed corner items per mode,
// then randomized phases; a behavioral buffer model predicts every result.
// Depends on msbuf_pkg and the multimode_sample_buffer_top RTL.
`timescale 1ns / 100ps

module multimode_sample_buffer_top_tb;
  import msbuf_pkg::*;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] ACT_NOP_FIRST = 3'd5;  // actions 5..7 do nothing
  localparam logic [2:0] ACT_NOP_LAST  = 3'd7;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // buffer model state
  logic [CNT_W-1:0] cfg_count = COUNT_RESET;
  logic [1:0] cfg_mode = MODE_LINEAR;
  logic [SAMPLE_W-1:0] sample_mem [DEPTH];
  bit sample_ok [DEPTH];
  bit touched [DEPTH];  // written at least once since reset
  logic [CNT_W-1:0] wr_pos = '0;
  int unsigned fill = 0;
  int unsigned head = 0;

  out_item_t expected_responses [$];
  out_item_t want;
  bit idle_on = 1'b1;
  int fail_count = 0;
  int unsigned cycle_count = 0;

  multimode_sample_buffer_top #(.DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multimode_sample_buffer_top test failed");
      $finish;
    end
  end

  function automatic int unsigned active_count();
    return (cfg_count > DEPTH) ? DEPTH : cfg_count;
  endfunction

  function automatic int unsigned map_entry(int unsigned idx, int unsigned n);
    return (cfg_mode == MODE_FIFO) ? (head + idx) % n : idx;
  endfunction

  function automatic void put_sample(int unsigned slot, logic [SAMPLE_W-1:0] v);
    sample_mem[slot] = v;
    sample_ok[slot] = 1'b1;
    touched[slot] = 1'b1;
  endfunction

  function automatic out_item_t buffer_response(in_item_t it);
    out_item_t r;
    int unsigned n, slot;
    n = active_count();
    r = '0;
    r.status = STATUS_OK;
    case (it.action)
      ACT_APPEND: begin
        if (n == 0) begin
          r.status = STATUS_RANGE;
        end else if (cfg_mode == MODE_LINEAR) begin
          // past the end the sample is dropped
          if (wr_pos < n) begin
            put_sample(wr_pos, it.sample_in);
            wr_pos++;
            if (fill < n) fill++;
          end
        end else if (cfg_mode == MODE_RING) begin
          slot = (wr_pos < n) ? wr_pos : 0;
          put_sample(slot, it.sample_in);
          wr_pos = (slot + 1 >= n) ? 0 : slot + 1;
          if (fill < n) fill++;
        end else if (cfg_mode == MODE_FIFO) begin
          slot = head % n;
          put_sample(slot, it.sample_in);
          head = (slot + 1 >= n) ? 0 : slot + 1;
          if (fill < n) fill++;
        end
      end
      ACT_READ: begin
        if (it.entry_index >= n) begin
          r.status = STATUS_RANGE;
        end else begin
          slot = map_entry(it.entry_index, n);
          r.read_value = sample_ok[slot] ? sample_mem[slot] : '0;
        end
      end
      ACT_WRITE: begin
        if (it.entry_index >= n) r.status = STATUS_RANGE;
        else put_sample(map_entry(it.entry_index, n), it.sample_in);
      end
      ACT_SETPOS: begin
        if (it.entry_index > n) r.status = STATUS_RANGE;
        else wr_pos = it.entry_index;
      end
      ACT_CLEAR: begin
        sample_ok = '{default: 1'b0};
        wr_pos = '0;
        fill = 0;
        head = 0;
      end
      default: ;
    endcase
    r.write_pos = wr_pos;
    r.full_res = (fill >= n);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_responses.size() == 0) begin
        $error("result with nothing pending: %p", out_item);
        fail_count++;
      end else begin
        want = expected_responses.pop_front();
        if (out_item.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_item.read_value);
          fail_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
        if (out_item.write_pos !== want.write_pos) begin
          $error("write_pos: expected %0d, got %0d", want.write_pos, out_item.write_pos);
          fail_count++;
        end
        if (out_item.full_res !== want.full_res) begin
          $error("full_res: expected %0d, got %0d", want.full_res, out_item.full_res);
          fail_count++;
        end
      end
    end
  end

  function automatic in_item_t item_of(logic [2:0] act, logic [CNT_W-1:0] idx,
                                       logic [SAMPLE_W-1:0] smp);
    in_item_t it;
    it.action = act;
    it.entry_index = idx;
    it.sample_in = smp;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    expected_responses.push_back(buffer_response(it));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    // a clear keeps the block busy after its result
    do @(posedge clk); while (in_stall);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_COUNT_ADDR) cfg_count = data[CNT_W-1:0];
    else if (addr == REG_MODE_ADDR) cfg_mode = data[1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned n, sel;
    n = active_count();
    sel = $urandom_range(999);
    if (sel < 430) it.action = ACT_APPEND;
    else if (sel < 680) it.action = ACT_READ;
    else if (sel < 830) it.action = ACT_WRITE;
    else if (sel < 930) it.action = ACT_SETPOS;
    else if (sel < 945) it.action = ACT_CLEAR;
    else it.action = ACT_NOP_FIRST + 3'($urandom_range(0, ACT_NOP_LAST - ACT_NOP_FIRST));
    sel = $urandom_range(99);
    if (sel < 70) it.entry_index = CNT_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
    else if (sel < 85) it.entry_index = CNT_W'(n + $urandom_range(0, 2) - ((n > 0) ? 1 : 0));
    else it.entry_index = CNT_W'($urandom_range(0, COUNT_MAX));
    sel = $urandom_range(99);
    if (sel < 10) it.sample_in = '1;
    else if (sel < 20) it.sample_in = '0;
    else it.sample_in = {$urandom, $urandom};
    // never fetch a slot that has not held a sample since reset
    if (it.action == ACT_READ && it.entry_index < n && !touched[map_entry(it.entry_index, n)])
      it.action = ACT_WRITE;
    return it;
  endfunction

  task automatic random_phase(input logic [CNT_W-1:0] count, input logic [1:0] mode,
                              input int unsigned items, input bit pause_mid);
    write_config(REG_COUNT_ADDR, PDATA_W'(count));
    write_config(REG_MODE_ADDR, PDATA_W'(mode));
    for (int unsigned i = 0; i < items; i++) begin
      if (pause_mid && i == items / 2) drain_results();
      send_item(random_item());
    end
    drain_results();
  endtask

  task automatic test_reset_and_linear();
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // clearing sweep after reset
    do @(posedge clk); while (in_stall);
    send_item(item_of(ACT_APPEND, '0, '1));
    send_item(item_of(ACT_APPEND, '0, '0));
    send_item(item_of(ACT_READ, 11'd0, '0));
    send_item(item_of(ACT_WRITE, 11'd1023, 64'h8000_0000_0000_0001));
    send_item(item_of(ACT_READ, 11'd1023, '1));
    send_item(item_of(ACT_READ, 11'd1024, '0));
    send_item(item_of(ACT_SETPOS, 11'd1025, '0));
    send_item(item_of(ACT_SETPOS, 11'd1024, '0));
    // at the end in linear mode: dropped
    send_item(item_of(ACT_APPEND, COUNT_MAX, 64'h0123_4567_89ab_cdef));
    send_item(item_of(ACT_NOP_FIRST, COUNT_MAX, '1));
    send_item(item_of(ACT_CLEAR, '0, '0));
    send_item(item_of(ACT_READ, 11'd0, '0));
    drain_results();
  endtask

  task automatic test_ring_wrap();
    write_config(REG_COUNT_ADDR, PDATA_W'(3));
    write_config(REG_MODE_ADDR, PDATA_W'(MODE_RING));
    for (int i = 0; i < 3; i++) send_item(item_of(ACT_APPEND, '0, {$urandom, $urandom}));
    send_item(item_of(ACT_SETPOS, 11'd3, '0));
    send_item(item_of(ACT_APPEND, '0, 64'hdead_beef_0000_ffff));
    drain_results();
  endtask

  task automatic test_fifo_order();
    write_config(REG_MODE_ADDR, PDATA_W'(MODE_FIFO));
    for (int i = 0; i < 4; i++) send_item(item_of(ACT_APPEND, '0, {$urandom, $urandom}));
    send_item(item_of(ACT_READ, 11'd0, '0));
    send_item(item_of(ACT_READ, 11'd2, '0));
    drain_results();
  endtask

  task automatic test_unused_mode_and_zero_count();
    write_config(REG_MODE_ADDR, PDATA_W'(MODE_UNUSED));
    send_item(item_of(ACT_APPEND, '0, '1));
    drain_results();
    write_config(REG_COUNT_ADDR, PDATA_W'(0));
    send_item(item_of(ACT_APPEND, '0, '1));
    send_item(item_of(ACT_READ, 11'd0, '0));
    send_item(item_of(ACT_SETPOS, 11'd0, '0));
    send_item(item_of(ACT_SETPOS, 11'd1, '0));
    drain_results();
  endtask

  task automatic test_random_mix();
    random_phase(11'd8, MODE_RING, 200, 1'b0);
    random_phase(11'd1024, MODE_FIFO, 150, 1'b0);
    random_phase(11'd5, MODE_FIFO, 200, 1'b0);
    random_phase(11'd1, MODE_LINEAR, 100, 1'b0);
    random_phase(11'd1, MODE_FIFO, 80, 1'b0);
    random_phase(11'd17, MODE_UNUSED, 80, 1'b0);
    random_phase(11'd0, MODE_RING, 60, 1'b0);
    random_phase(11'd64, MODE_LINEAR, 200, 1'b0);
    random_phase(CNT_W'($urandom_range(1, COUNT_MAX)), 2'($urandom_range(0, 3)), 150, 1'b0);
    random_phase(11'd1024, MODE_RING, 200, 1'b0);
  endtask

  task automatic test_no_idle_stretch();
    idle_on = 1'b0;
    random_phase(COUNT_MAX, MODE_RING, 250, 1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    random_phase(11'd300, MODE_FIFO, 200, 1'b1);
  endtask

  initial begin
    sample_ok = '{default: 1'b0};
    touched = '{default: 1'b0};
    test_reset_and_linear();
    test_ring_wrap();
    test_fifo_order();
    test_unused_mode_and_zero_count();
    test_random_mix();
    test_no_idle_stretch();
    test_pause_until_drained();
    if (fail_count == 0 && expected_responses.size() == 0)
      $display("multimode_sample_buffer_top test passed");
    else
      $display("multimode_sample_buffer_top test failed");
    $finish;
  end

endmodule

>>> multimode_sample_buffer_top.f
hw/rtl/msbuf_pkg.sv
hw/rtl/multimode_sample_buffer_top.sv
bench/multimode_sample_buffer_top_tb.sv
